// ===== hdl/hfde_pkg.sv =====
// Shared types, sizes, codes and helpers for the Hermite fractional delay echo block.
// Used by hermite_fractional_delay_echo; depends on nothing else.
`timescale 1ns / 1ps

package hfde_pkg;

   // Ring length per channel (a power of two) and channel count.
   localparam int BUFFER_LEN = 65536;
   localparam int CHANNELS   = 2;

   localparam int POS_W      = $clog2(BUFFER_LEN);
   localparam int MAIN_DEPTH = CHANNELS * BUFFER_LEN;
   localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
   localparam int ECHO_DEPTH = 2 * MAIN_DEPTH;
   localparam int ECHO_AW    = $clog2(ECHO_DEPTH);

   localparam int SAMPLE_W = 24;
   localparam int FRAC_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int EDLY_W   = 16;
   localparam int ACC_W    = 30;
   localparam int MUL_B_W  = FRAC_W + 1;
   localparam int PROD_W   = ACC_W + MUL_B_W;
   localparam int TAPS     = 4;
   localparam int FB_SHIFT = 15;
   localparam int CSR_AW   = 4;

   localparam logic signed [31:0] SAT_MAX = 32'sd8388607;
   localparam logic signed [31:0] SAT_MIN = -32'sd8388608;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [POS_W-1:0]           pos_type;

   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_ECHO_A = 2'd1;
   localparam req_kind_type REQ_ECHO_B = 2'd2;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_DELAY_WHOLE_CH0    = 2'd0;
   localparam reg_index_type REG_DELAY_FRACTION_CH0 = 2'd1;
   localparam reg_index_type REG_DELAY_WHOLE_CH1    = 2'd2;
   localparam reg_index_type REG_DELAY_FRACTION_CH1 = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_COEF,
      ST_MUL,
      ST_ADD,
      ST_HALF,
      ST_FB_MUL,
      ST_FB_WRITE,
      ST_DONE
   } state_type;

   function automatic sample_type sat24(input logic signed [31:0] v);
      if (v > SAT_MAX) begin
         return sample_type'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         return sample_type'(SAT_MIN);
      end
      return sample_type'(v);
   endfunction

endpackage

// ===== hdl/hermite_fractional_delay_echo.sv =====
// Top level of the two-channel Hermite fractional delay line with echo feedback.
// Depends on hfde_pkg and hfde_ram.
`timescale 1ns / 1ps

// Each request reads four taps of its channel's main ring around write position minus the
// whole delay, interpolates them with a 4-point Hermite polynomial in the Q0.16 fraction,
// optionally adds one tap of echo bank A or B, and returns one saturated Q1.23 sample. The input
// is ready only while the sequencer is idle, so a new request is taken only once the last one
// has reached the output register. The pace of requests is set by the four tap reads through
// the single read port of the main ring memory and by the one shared multiplier, which runs
// the three Horner steps and the feedback product one after another.
// Results wait in an output register, so a new request is accepted while one is unread. The
// ring memories are not swept after reset: every ring keeps a write position and a full flag,
// and a tap that was never written since reset reads as zero, so the block is ready right away.

module hermite_fractional_delay_echo
   import hfde_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // sample_in [23:0], echo_delay [39:24], feedback_gain [55:40]
   input  logic [55:0]       req_tdata,
   // req_type [1:0], channel [2]
   input  logic [2:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // sample_out [23:0]
   output logic [23:0]       rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // Configuration registers.
   logic [15:0] dwhole_ff [2];
   logic [15:0] dwhole_in [2];
   logic [15:0] dfrac_ff  [2];
   logic [15:0] dfrac_in  [2];

   // Sequencer state.
   state_type    state_ff, state_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [1:0]   it_ff, it_in;
   logic         cap_ff, cap_in;
   logic         ecap_ff, ecap_in;
   logic         out_valid_ff, out_valid_in;

   // Ring positions and fill flags.
   pos_type      main_wpos_ff [CHANNELS];
   pos_type      main_wpos_in [CHANNELS];
   logic         main_full_ff [CHANNELS];
   logic         main_full_in [CHANNELS];
   pos_type      echo_wpos_ff [2][CHANNELS];
   pos_type      echo_wpos_in [2][CHANNELS];
   logic         echo_full_ff [2][CHANNELS];
   logic         echo_full_in [2][CHANNELS];

   // Request and datapath payload.
   req_kind_type kind_ff, kind_in;
   logic [0:0]   ch_ff, ch_in;
   sample_type   sample_ff, sample_in;
   logic [EDLY_W-1:0] edly_ff, edly_in;
   logic signed [GAIN_W-1:0] gain_ff, gain_in;
   logic [1:0]   cap_idx_ff, cap_idx_in;
   logic         cap_ok_ff, cap_ok_in;
   logic         ecap_ok_ff, ecap_ok_in;
   sample_type   tap_ff [TAPS];
   sample_type   tap_in [TAPS];
   sample_type   etap_ff, etap_in;
   acc_type      k_ff [3];
   acc_type      k_in [3];
   acc_type      a_ff, a_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   sample_type   y_ff, y_in;
   sample_type   out_data_ff, out_data_in;

   // Combinational helpers.
   logic          cfg_write;
   reg_index_type cfg_index;
   logic          req_accept;
   logic          echo_mode;
   logic [0:0]    bank;
   pos_type       mwpos, ewpos, dpos, main_q, echo_q;
   logic          mfull, efull, main_q_ok, echo_q_ok;
   logic [15:0]   frac;
   acc_type       tp0, tp1, tp2, tp3, hsum, hval;
   acc_type       mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  fb_sum;
   logic [1:0]    k_sel;

   // Memory ports.
   logic                main_we, echo_we;
   logic [MAIN_AW-1:0]  main_waddr, main_raddr;
   logic [ECHO_AW-1:0]  echo_waddr, echo_raddr;
   logic [SAMPLE_W-1:0] main_wdata, echo_wdata, main_rdata, echo_rdata;

   hfde_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAIN_DEPTH)
   ) u_main_ram (
      .clock   (clock),
      .wr_en   (main_we),
      .wr_addr (main_waddr),
      .wr_data (main_wdata),
      .rd_addr (main_raddr),
      .rd_data (main_rdata)
   );

   hfde_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (ECHO_DEPTH)
   ) u_echo_ram (
      .clock   (clock),
      .wr_en   (echo_we),
      .wr_addr (echo_waddr),
      .wr_data (echo_wdata),
      .rd_addr (echo_raddr),
      .rd_data (echo_rdata)
   );

   // ---------------------------------------------------------------- configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;
   assign cfg_index  = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      dwhole_in = dwhole_ff;
      dfrac_in  = dfrac_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_DELAY_WHOLE_CH0:    dwhole_in[0] = csr_pwdata[15:0];
            REG_DELAY_FRACTION_CH0: dfrac_in[0]  = csr_pwdata[15:0];
            REG_DELAY_WHOLE_CH1:    dwhole_in[1] = csr_pwdata[15:0];
            REG_DELAY_FRACTION_CH1: dfrac_in[1]  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         REG_DELAY_WHOLE_CH0:    csr_prdata = {16'd0, dwhole_ff[0]};
         REG_DELAY_FRACTION_CH0: csr_prdata = {16'd0, dfrac_ff[0]};
         REG_DELAY_WHOLE_CH1:    csr_prdata = {16'd0, dwhole_ff[1]};
         REG_DELAY_FRACTION_CH1: csr_prdata = {16'd0, dfrac_ff[1]};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------------------------------------------------------- current request view
   assign echo_mode = (kind_ff == REQ_ECHO_A) || (kind_ff == REQ_ECHO_B);
   assign bank      = (kind_ff == REQ_ECHO_B);
   assign mwpos     = main_wpos_ff[ch_ff];
   assign mfull     = main_full_ff[ch_ff];
   assign ewpos     = echo_wpos_ff[bank][ch_ff];
   assign efull     = echo_full_ff[bank][ch_ff];
   assign dpos      = pos_type'(dwhole_ff[ch_ff]);
   assign frac      = dfrac_ff[ch_ff];

   // A ring entry holds data once its write position has passed it or the ring has wrapped.
   assign main_q    = mwpos - dpos - pos_type'(cnt_ff);
   assign main_q_ok = mfull | (main_q < mwpos);
   assign echo_q    = ewpos - pos_type'(edly_ff);
   assign echo_q_ok = efull | (echo_q < ewpos);

   assign main_raddr = MAIN_AW'({ch_ff, main_q});
   assign echo_raddr = {bank, MAIN_AW'({ch_ff, echo_q})};

   assign tp0 = acc_type'(tap_ff[0]);
   assign tp1 = acc_type'(tap_ff[1]);
   assign tp2 = acc_type'(tap_ff[2]);
   assign tp3 = acc_type'(tap_ff[3]);

   assign hsum   = a_ff + acc_type'(1);
   assign hval   = hsum >>> 1;
   assign fb_sum = (prod_ff + PROD_W'(2 ** (FB_SHIFT - 1))) >>> FB_SHIFT;
   assign k_sel  = 2'd2 - it_ff;

   // The shared multiplier runs the Horner steps and the feedback product.
   always_comb begin
      if (state_ff == ST_FB_MUL) begin
         mul_a = acc_type'(y_ff);
         mul_b = MUL_B_W'(gain_ff);
      end else begin
         mul_a = a_ff;
         mul_b = signed'({1'b0, frac});
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_accept) state_in = ST_READ;
         ST_READ:     if (cnt_ff == 3'd4) state_in = ST_COEF;
         ST_COEF:     state_in = ST_MUL;
         ST_MUL:      state_in = ST_ADD;
         ST_ADD:      state_in = (it_ff == 2'd2) ? ST_HALF : ST_MUL;
         ST_HALF:     state_in = echo_mode ? ST_FB_MUL : ST_DONE;
         ST_FB_MUL:   state_in = ST_FB_WRITE;
         ST_FB_WRITE: state_in = ST_DONE;
         ST_DONE:     if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath and memory control
   always_comb begin
      cnt_in       = cnt_ff;
      it_in        = it_ff;
      cap_in       = 1'b0;
      ecap_in      = 1'b0;
      cap_idx_in   = cnt_ff[1:0];
      cap_ok_in    = main_q_ok;
      ecap_ok_in   = echo_q_ok;
      out_valid_in = out_valid_ff & ~rsp_tready;
      main_wpos_in = main_wpos_ff;
      main_full_in = main_full_ff;
      echo_wpos_in = echo_wpos_ff;
      echo_full_in = echo_full_ff;
      kind_in      = kind_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      edly_in      = edly_ff;
      gain_in      = gain_ff;
      tap_in       = tap_ff;
      etap_in      = etap_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      prod_in      = prod_ff;
      y_in         = y_ff;
      out_data_in  = out_data_ff;
      main_we      = 1'b0;
      main_waddr   = MAIN_AW'({ch_ff, mwpos});
      main_wdata   = sample_ff;
      echo_we      = 1'b0;
      echo_waddr   = {bank, MAIN_AW'({ch_ff, ewpos})};
      echo_wdata   = sat24(32'(fb_sum));

      // Read data arrives in the cycle after its address; unwritten entries read as zero.
      if (cap_ff) begin
         tap_in[cap_idx_ff] = cap_ok_ff ? signed'(main_rdata) : '0;
      end
      if (ecap_ff) begin
         etap_in = ecap_ok_ff ? signed'(echo_rdata) : '0;
      end

      case (state_ff)
         ST_IDLE: begin
            cnt_in    = 3'd0;
            kind_in   = req_kind_type'(req_tuser[1:0]);
            ch_in     = (CHANNELS > 1) ? req_tuser[2] : 1'b0;
            sample_in = signed'(req_tdata[23:0]);
            edly_in   = req_tdata[39:24];
            gain_in   = signed'(req_tdata[55:40]);
         end
         ST_READ: begin
            cap_in  = (cnt_ff < 3'd4);
            ecap_in = (cnt_ff == 3'd0);
            cnt_in  = cnt_ff + 3'd1;
         end
         ST_COEF: begin
            k_in[0] = tp1 + tp1;
            k_in[1] = tp2 - tp0;
            k_in[2] = (tp0 + tp0) - (tp1 <<< 2) - tp1 + (tp2 <<< 2) - tp3;
            a_in    = tp3 - tp0 + (tp1 + tp1 + tp1) - (tp2 + tp2 + tp2);
            it_in   = 2'd0;
         end
         ST_MUL: begin
            prod_in = mul_a * mul_b;
         end
         ST_ADD: begin
            a_in  = acc_type'(prod_ff >>> FRAC_W) + k_ff[k_sel];
            it_in = it_ff + 2'd1;
         end
         ST_HALF: begin
            if (echo_mode) begin
               y_in = sat24(32'(hval) + 32'(etap_ff));
            end else begin
               y_in = sat24(32'(hval));
            end
            main_we             = 1'b1;
            main_wpos_in[ch_ff] = mwpos + pos_type'(1);
            main_full_in[ch_ff] = mfull | (mwpos == '1);
         end
         ST_FB_MUL: begin
            prod_in = mul_a * mul_b;
         end
         ST_FB_WRITE: begin
            echo_we                   = 1'b1;
            echo_wpos_in[bank][ch_ff] = ewpos + pos_type'(1);
            echo_full_in[bank][ch_ff] = efull | (ewpos == '1);
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = y_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         it_ff        <= '0;
         cap_ff       <= 1'b0;
         ecap_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         dwhole_ff    <= '{default: '0};
         dfrac_ff     <= '{default: '0};
         main_wpos_ff <= '{default: '0};
         main_full_ff <= '{default: 1'b0};
         echo_wpos_ff <= '{default: '{default: '0}};
         echo_full_ff <= '{default: '{default: 1'b0}};
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         it_ff        <= it_in;
         cap_ff       <= cap_in;
         ecap_ff      <= ecap_in;
         out_valid_ff <= out_valid_in;
         dwhole_ff    <= dwhole_in;
         dfrac_ff     <= dfrac_in;
         main_wpos_ff <= main_wpos_in;
         main_full_ff <= main_full_in;
         echo_wpos_ff <= echo_wpos_in;
         echo_full_ff <= echo_full_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      edly_ff     <= edly_in;
      gain_ff     <= gain_in;
      cap_idx_ff  <= cap_idx_in;
      cap_ok_ff   <= cap_ok_in;
      ecap_ok_ff  <= ecap_ok_in;
      tap_ff      <= tap_in;
      etap_ff     <= etap_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      prod_ff     <= prod_in;
      y_ff        <= y_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ===== hdl/hfde_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone; used for the delay ring stores.
`timescale 1ns / 1ps

module hfde_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for hermite_fractional_delay_echo: streams requests with random
// gaps, predicts every output sample from a local copy of the rings and delay registers.
// Depends on hfde_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_top;
   import hfde_pkg::*;

   localparam req_kind_type REQ_PLAIN = 2'd0;
   localparam req_kind_type REQ_SPARE = 2'd3;
   localparam logic [23:0] Q23_MAX = 24'h7FFFFF;
   localparam logic [23:0] Q23_MIN = 24'h800000;
   localparam logic [15:0] GAIN_MAX = 16'h7FFF;
   localparam logic [15:0] GAIN_MIN = 16'h8000;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES = 24;

   typedef bit signed [SAMPLE_W-1:0] stored_sample_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        chan;
      logic [23:0] sample;
      logic [15:0] echo_dly;
      logic [15:0] gain;
   } request_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [55:0]       req_tdata = '0;
   logic [2:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   hermite_fractional_delay_echo u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Local image of the block: delay registers, rings and write positions.
   bit [15:0]    delay_whole_cfg [CHANNELS];
   bit [15:0]    delay_frac_cfg [CHANNELS];
   stored_sample_type main_store [CHANNELS][BUFFER_LEN];
   stored_sample_type echo_store [2][CHANNELS][BUFFER_LEN];
   pos_type      main_wpos [CHANNELS];
   pos_type      echo_wpos [2][CHANNELS];

   request_type  queued_requests [$];
   logic [23:0]  expected_samples [$];
   request_type  current_request;
   bit           send_busy = 1'b0;
   int           send_gap = 0;
   int           send_burst = 0;
   int           recv_stall = 0;
   int           recv_burst = 0;
   int           quiet_cycles = 0;
   int           mismatch_count = 0;
   bit           timed_out = 1'b0;

   function automatic stored_sample_type clamp_q23(input longint v);
      if (v > 64'sd8388607) begin
         return stored_sample_type'(Q23_MAX);
      end else if (v < -64'sd8388608) begin
         return stored_sample_type'(Q23_MIN);
      end
      return stored_sample_type'(v);
   endfunction

   // Interpolates the main ring, adds the echo tap where asked, and updates the rings.
   function automatic logic [23:0] predict_delay_echo(input request_type r);
      int      ch;
      int      bank;
      pos_type tp;
      pos_type ew;
      longint  p, y1, y2, y3, k0, k1, k2, k3, f, acc, interp, tap, gain;
      stored_sample_type result;
      ch = int'(r.chan);
      tp = main_wpos[ch] - pos_type'(delay_whole_cfg[ch]);
      p  = longint'(main_store[ch][tp]);
      y1 = longint'(main_store[ch][pos_type'(tp - 1)]);
      y2 = longint'(main_store[ch][pos_type'(tp - 2)]);
      y3 = longint'(main_store[ch][pos_type'(tp - 3)]);
      k0 = 2 * y1;
      k1 = y2 - p;
      k2 = 2 * p - 5 * y1 + 4 * y2 - y3;
      k3 = y3 - p + 3 * y1 - 3 * y2;
      f = longint'(delay_frac_cfg[ch]);
      // Arithmetic right shifts of signed values round toward minus infinity.
      acc = k3;
      acc = ((acc * f) >>> 16) + k2;
      acc = ((acc * f) >>> 16) + k1;
      acc = ((acc * f) >>> 16) + k0;
      interp = (acc + 1) >>> 1;
      if (r.kind == REQ_ECHO_A || r.kind == REQ_ECHO_B) begin
         bank = (r.kind == REQ_ECHO_A) ? 0 : 1;
         ew = echo_wpos[bank][ch];
         tap = longint'(echo_store[bank][ch][pos_type'(ew - pos_type'(r.echo_dly))]);
         result = clamp_q23(interp + tap);
         gain = longint'($signed(r.gain));
         echo_store[bank][ch][ew] = clamp_q23((gain * longint'(result) + 16384) >>> 15);
         echo_wpos[bank][ch] = ew + 1'b1;
      end else begin
         result = clamp_q23(interp);
      end
      main_store[ch][main_wpos[ch]] = stored_sample_type'($signed(r.sample));
      main_wpos[ch] = main_wpos[ch] + 1'b1;
      return result;
   endfunction

   // Half of the pauses are zero, most others short and a few long; now and then a
   // stretch of back-to-back cycles with no pause at all.
   function automatic int draw_pause(inout int burst);
      int pick;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      pick = $urandom_range(0, 199);
      if (pick == 0) begin
         burst = $urandom_range(40, 120);
         return 0;
      end else if (pick < 100) begin
         return 0;
      end else if (pick < 170) begin
         return $urandom_range(1, 16);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic request_type random_request();
      request_type r;
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 6) begin
         r.kind = REQ_PLAIN;
      end else if (pick < 10) begin
         r.kind = REQ_ECHO_A;
      end else if (pick < 14) begin
         r.kind = REQ_ECHO_B;
      end else begin
         r.kind = REQ_SPARE;
      end
      r.chan = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 7);
      case (pick)
         0: r.sample = Q23_MAX;
         1: r.sample = Q23_MIN;
         2: r.sample = 24'($signed($urandom_range(0, 511)) - 256);
         default: r.sample = 24'($urandom);
      endcase
      // Short echo delays mostly land on samples already written; a few reach far back.
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         r.echo_dly = 16'($urandom_range(0, 24));
      end else if (pick == 8) begin
         r.echo_dly = 16'hFFFF;
      end else begin
         r.echo_dly = 16'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         r.gain = GAIN_MAX;
      end else if (pick == 1) begin
         r.gain = GAIN_MIN;
      end else begin
         r.gain = 16'($urandom);
      end
      return r;
   endfunction

   function automatic request_type make_request(input req_kind_type kind, input bit chan,
                                                input logic [23:0] sample,
                                                input logic [15:0] echo_dly,
                                                input logic [15:0] gain);
      request_type r;
      r.kind = kind;
      r.chan = chan;
      r.sample = sample;
      r.echo_dly = echo_dly;
      r.gain = gain;
      return r;
   endfunction

   task automatic csr_write(input reg_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_DELAY_WHOLE_CH0:    delay_whole_cfg[0] = value;
         REG_DELAY_FRACTION_CH0: delay_frac_cfg[0] = value;
         REG_DELAY_WHOLE_CH1:    delay_whole_cfg[1] = value;
         REG_DELAY_FRACTION_CH1: delay_frac_cfg[1] = value;
         default: ;
      endcase
   endtask

   task automatic write_delays(input logic [15:0] whole0, input logic [15:0] frac0,
                               input logic [15:0] whole1, input logic [15:0] frac1);
      csr_write(REG_DELAY_WHOLE_CH0, whole0);
      csr_write(REG_DELAY_FRACTION_CH0, frac0);
      csr_write(REG_DELAY_WHOLE_CH1, whole1);
      csr_write(REG_DELAY_FRACTION_CH1, frac1);
   endtask

   // The sender holds off until every request has been answered. A request taken from
   // the queue counts as busy until it is accepted, so no edge can slip through.
   task automatic wait_drained();
      while (queued_requests.size() != 0 || send_busy || expected_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(predict_delay_echo(current_request));
            send_busy = 1'b0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               current_request = queued_requests.pop_front();
               send_busy = 1'b1;
               req_tdata <= {current_request.gain, current_request.echo_dly,
                             current_request.sample};
               req_tuser <= {current_request.chan, current_request.kind};
               req_tvalid <= 1'b1;
               send_gap = draw_pause(send_burst);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample_out: expected none, got %0d", $time,
                        $signed(rsp_tdata));
               mismatch_count++;
            end else if (rsp_tdata !== expected_samples[0]) begin
               $display("%0t: sample_out mismatch: expected %0d, got %0d", $time,
                        $signed(expected_samples[0]), $signed(rsp_tdata));
               mismatch_count++;
               void'(expected_samples.pop_front());
            end else begin
               void'(expected_samples.pop_front());
            end
         end
         if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = draw_pause(recv_burst);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      fork
         begin
            repeat (9) @(posedge clock);
            reset <= 1'b0;
            @(posedge clock);

            // Reset settings: zero delay and zero fraction, so each plain output is the
            // previous sample of its channel; the oldest entry is the one overwritten.
            queued_requests.push_back(make_request(REQ_PLAIN, 0, Q23_MAX, 16'h0, 16'h0));
            queued_requests.push_back(make_request(REQ_PLAIN, 0, Q23_MIN, 16'h0, 16'h0));
            queued_requests.push_back(make_request(REQ_ECHO_A, 0, 24'h0, 16'h0, GAIN_MAX));
            queued_requests.push_back(make_request(REQ_ECHO_B, 1, Q23_MAX, 16'h1, GAIN_MIN));
            queued_requests.push_back(make_request(REQ_SPARE, 1, Q23_MIN, 16'hFFFF, GAIN_MAX));
            queued_requests.push_back(make_request(REQ_ECHO_A, 0, Q23_MAX, 16'h1, GAIN_MAX));
            queued_requests.push_back(make_request(REQ_ECHO_A, 0, Q23_MAX, 16'h1, GAIN_MAX));
            queued_requests.push_back(make_request(REQ_ECHO_A, 0, Q23_MIN, 16'hFFFF, GAIN_MIN));
            queued_requests.push_back(make_request(REQ_ECHO_B, 1, Q23_MIN, 16'h2, GAIN_MIN));
            queued_requests.push_back(make_request(REQ_ECHO_B, 1, Q23_MIN, 16'hFFFF, GAIN_MAX));
            queued_requests.push_back(make_request(REQ_SPARE, 0, 24'h000001, 16'h5, 16'h0));
            wait_drained();

            // Half-sample fraction on alternating full-scale input overshoots the range.
            write_delays(16'd1, 16'h8000, 16'd0, 16'hFFFF);
            for (int i = 0; i < 12; i++) begin
               queued_requests.push_back(make_request((i % 3 == 2) ? REQ_ECHO_B : REQ_PLAIN,
                                                      i[2], i[0] ? Q23_MIN : Q23_MAX,
                                                      16'h3, GAIN_MAX));
            end
            wait_drained();

            for (int phase = 0; phase < 7; phase++) begin
               case (phase)
                  0: write_delays(16'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
                  1: write_delays(16'hFFFF, 16'hFFFF, 16'd0, 16'h0000);
                  2: write_delays(16'd2, 16'h0001, 16'd7, 16'hFFFE);
                  default: write_delays(16'($urandom_range(0, 30)), 16'($urandom),
                                        16'($urandom_range(0, 30)), 16'($urandom));
               endcase
               for (int i = 0; i < 200; i++) begin
                  queued_requests.push_back(random_request());
               end
               wait_drained();
            end

            repeat (TAIL_CYCLES) @(posedge clock);
         end
         begin
            wait (quiet_cycles >= WATCHDOG_LIMIT);
            timed_out = 1'b1;
         end
      join_any

      if (expected_samples.size() != 0) begin
         $display("%0t: %0d expected samples never arrived", $time, expected_samples.size());
         mismatch_count++;
      end
      if (timed_out || mismatch_count != 0) begin
         $display("tb_top: FAIL");
      end else begin
         $display("tb_top: PASS");
      end
      $finish;
   end

endmodule
